>>> src/blr_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package blr_pkg;

	// color field width, fixed by the pixel format
	localparam int COLOR_BITS = 24;

	// item kind carried in the input tuser
	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_STEP = 1'b1
	} blr_mode_t;

	// per-line orientation flags
	typedef struct packed {
		logic steep;    // y is the major axis
		logic dir_neg;  // minor coordinate decreases
	} blr_flags_t;

endpackage

>>> src/blr_setup.sv
// Line setup: picks the major axis, orders endpoints, builds the error terms.
// Depends on blr_pkg for the orientation flag struct.
`timescale 1ns / 1ps

module blr_setup import blr_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic signed [COORD_BITS-1:0] x0,
	input  logic signed [COORD_BITS-1:0] y0,
	input  logic signed [COORD_BITS-1:0] x1,
	input  logic signed [COORD_BITS-1:0] y1,
	output logic signed [COORD_BITS-1:0] major_init,
	output logic signed [COORD_BITS-1:0] minor_init,
	output logic signed [COORD_BITS-1:0] major_stop,
	output logic        [COORD_BITS:0]   twice_minor,
	output logic signed [COORD_BITS+1:0] twice_diff,
	output logic signed [COORD_BITS+2:0] err_init,
	output blr_flags_t                   flags,
	output logic                         zero_len
);

	logic signed [COORD_BITS:0]   dx, dy, ndx, ndy, dmaj_raw, dmin_raw;
	logic        [COORD_BITS-1:0] adx, ady, dmaj, dmin;
	logic signed [COORD_BITS-1:0] maj0, maj1, min0, min1;
	logic                         steep, swapped;
	logic        [COORD_BITS+1:0] diff;

	// signed deltas and their magnitudes
	always_comb begin
		dx  = $signed({x1[COORD_BITS-1], x1}) - $signed({x0[COORD_BITS-1], x0});
		dy  = $signed({y1[COORD_BITS-1], y1}) - $signed({y0[COORD_BITS-1], y0});
		ndx = -dx;
		ndy = -dy;
		adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
	end

	// axis choice and endpoint ordering
	always_comb begin
		steep    = adx < ady;
		dmaj_raw = steep ? dy : dx;
		dmin_raw = steep ? dx : dy;
		dmaj     = steep ? ady : adx;
		dmin     = steep ? adx : ady;
		maj0     = steep ? y0 : x0;
		maj1     = steep ? y1 : x1;
		min0     = steep ? x0 : y0;
		min1     = steep ? x1 : y1;
		swapped  = dmaj_raw[COORD_BITS];

		major_init = swapped ? maj1 : maj0;
		major_stop = swapped ? maj0 : maj1;
		minor_init = swapped ? min1 : min0;

		flags.steep   = steep;
		flags.dir_neg = (dmin_raw != '0) && (dmin_raw[COORD_BITS] != swapped);
		zero_len      = (dmaj == '0);
	end

	// error term constants
	always_comb begin
		twice_minor = {dmin, 1'b0};
		diff        = {2'b00, dmin} - {2'b00, dmaj};
		twice_diff  = $signed({diff[COORD_BITS:0], 1'b0});
		err_init    = $signed({2'b00, dmin, 1'b0} - {3'b000, dmaj});
	end

endmodule

>>> src/blr_step.sv
// Pixel step: emits the current pixel and advances the error term one column.
// Depends on blr_pkg for the orientation flag struct.
`timescale 1ns / 1ps

module blr_step import blr_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic signed [COORD_BITS-1:0] major_pos,
	input  logic signed [COORD_BITS-1:0] minor_pos,
	input  logic signed [COORD_BITS-1:0] major_stop,
	input  logic signed [COORD_BITS+2:0] err,
	input  logic        [COORD_BITS:0]   twice_minor,
	input  logic signed [COORD_BITS+1:0] twice_diff,
	input  blr_flags_t                   flags,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic signed [COORD_BITS-1:0] major_nx,
	output logic signed [COORD_BITS-1:0] minor_nx,
	output logic signed [COORD_BITS+2:0] err_nx,
	output logic                         last
);

	logic signed [COORD_BITS:0] major_inc;

	// current pixel in screen axes
	always_comb begin
		pixel_x = flags.steep ? minor_pos : major_pos;
		pixel_y = flags.steep ? major_pos : minor_pos;
	end

	// error update and minor move
	always_comb begin
		if (err > 0) begin
			minor_nx = flags.dir_neg ? minor_pos - {{(COORD_BITS-1){1'b0}}, 1'b1}
				: minor_pos + {{(COORD_BITS-1){1'b0}}, 1'b1};
			err_nx   = err + {{1{twice_diff[COORD_BITS+1]}}, twice_diff};
		end else begin
			minor_nx = minor_pos;
			err_nx   = err + $signed({2'b00, twice_minor});
		end
	end

	// major advance and end test
	always_comb begin
		major_inc = $signed({major_pos[COORD_BITS-1], major_pos})
			+ $signed({{COORD_BITS{1'b0}}, 1'b1});
		major_nx  = major_inc[COORD_BITS-1:0];
		last      = major_inc >= $signed({major_stop[COORD_BITS-1], major_stop});
	end

endmodule

>>> src/bresenham_line_rasterizer_unit.sv
// Top level of the Bresenham line rasterizer: beat registers and line state.
// Depends on blr_pkg, blr_setup and blr_step.
//
//  channel   dir  tdata (low bit up)                          side
//  s_axis    in   x_start, y_start, x_end, y_end, line_color  tuser: mode
//  m_axis    out  pixel_x, pixel_y, pixel_color               tlast: last_pixel
//
// One beat in, one pixel out per clock unless stalled; registered at input and result.
// The path per cycle is line setup feeding one error-term step, input register to result.
// Reset clears the line state; the block comes up idle with no line loaded.
// A stalled output holds its pixel and stops the input register behind it.
// Step beats with no line loaded and zero-length loads produce no pixel.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_unit import blr_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// x_start, y_start, x_end, y_end, line_color
	input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
	// mode
	input  logic                                          s_axis_tuser,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// pixel_x, pixel_y, pixel_color
	output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic                                          m_axis_tlast
);

	localparam int C          = COORD_BITS;
	localparam int OUT_DATA_W = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

	// input register
	logic                   valid_s1;
	blr_mode_t              mode_s1;
	logic signed [C-1:0]    x0_s1, y0_s1, x1_s1, y1_s1;
	logic [COLOR_BITS-1:0]  color_s1;

	// line state
	logic signed [C-1:0]    major_q, minor_q, stop_q;
	logic signed [C+2:0]    err_q;
	logic        [C:0]      tmd_q;
	logic signed [C+1:0]    tdd_q;
	blr_flags_t             flags_q;
	logic                   active_q;
	logic [COLOR_BITS-1:0]  color_q;

	// result register
	logic                   out_valid_q;
	logic signed [C-1:0]    pixel_x_q, pixel_y_q;
	logic [COLOR_BITS-1:0]  pixel_color_q;
	logic                   last_q;

	// setup outputs
	logic signed [C-1:0]    su_major, su_minor, su_stop;
	logic        [C:0]      su_tmd;
	logic signed [C+1:0]    su_tdd;
	logic signed [C+2:0]    su_err;
	blr_flags_t             su_flags;
	logic                   su_zero;

	// operands for the step
	logic signed [C-1:0]    cur_major, cur_minor, cur_stop;
	logic        [C:0]      cur_tmd;
	logic signed [C+1:0]    cur_tdd;
	logic signed [C+2:0]    cur_err;
	blr_flags_t             cur_flags;

	// step outputs
	logic signed [C-1:0]    st_px, st_py, st_major, st_minor;
	logic signed [C+2:0]    st_err;
	logic                   st_last;

	logic                   is_load, emit, fire;

	blr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.x0          (x0_s1),
		.y0          (y0_s1),
		.x1          (x1_s1),
		.y1          (y1_s1),
		.major_init  (su_major),
		.minor_init  (su_minor),
		.major_stop  (su_stop),
		.twice_minor (su_tmd),
		.twice_diff  (su_tdd),
		.err_init    (su_err),
		.flags       (su_flags),
		.zero_len    (su_zero)
	);

	// a load steps from fresh setup values, a step beat from the held line
	always_comb begin
		is_load   = (mode_s1 == MODE_LOAD);
		cur_major = is_load ? su_major : major_q;
		cur_minor = is_load ? su_minor : minor_q;
		cur_stop  = is_load ? su_stop  : stop_q;
		cur_tmd   = is_load ? su_tmd   : tmd_q;
		cur_tdd   = is_load ? su_tdd   : tdd_q;
		cur_err   = is_load ? su_err   : err_q;
		cur_flags = is_load ? su_flags : flags_q;
		emit      = is_load ? !su_zero : active_q;
	end

	blr_step #(.COORD_BITS(COORD_BITS)) u_step (
		.major_pos   (cur_major),
		.minor_pos   (cur_minor),
		.major_stop  (cur_stop),
		.err         (cur_err),
		.twice_minor (cur_tmd),
		.twice_diff  (cur_tdd),
		.flags       (cur_flags),
		.pixel_x     (st_px),
		.pixel_y     (st_py),
		.major_nx    (st_major),
		.minor_nx    (st_minor),
		.err_nx      (st_err),
		.last        (st_last)
	);

	// handshake: the held beat moves on when the result register can take it
	assign fire          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1  <= blr_mode_t'(s_axis_tuser);
			x0_s1    <= s_axis_tdata[C-1:0];
			y0_s1    <= s_axis_tdata[2*C-1:C];
			x1_s1    <= s_axis_tdata[3*C-1:2*C];
			y1_s1    <= s_axis_tdata[4*C-1:3*C];
			color_s1 <= s_axis_tdata[4*C+COLOR_BITS-1:4*C];
		end
	end

	// line state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q  <= '0;
			minor_q  <= '0;
			stop_q   <= '0;
			err_q    <= '0;
			tmd_q    <= '0;
			tdd_q    <= '0;
			flags_q  <= '0;
			active_q <= 1'b0;
			color_q  <= '0;
		end else if (fire) begin
			if (is_load) begin
				stop_q  <= su_stop;
				tmd_q   <= su_tmd;
				tdd_q   <= su_tdd;
				flags_q <= su_flags;
				color_q <= color_s1;
			end
			major_q  <= emit ? st_major : cur_major;
			minor_q  <= emit ? st_minor : cur_minor;
			err_q    <= emit ? st_err   : cur_err;
			active_q <= emit && !st_last;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			pixel_x_q     <= st_px;
			pixel_y_q     <= st_py;
			pixel_color_q <= is_load ? color_s1 : color_q;
			last_q        <= st_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({pixel_color_q, pixel_y_q, pixel_x_q});
	assign m_axis_tlast  = last_q;

	// a beat that plots nothing leaves the output empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !emit) |=> !m_axis_tvalid)
		else $error("output valid after a beat with no pixel");

	// an active line has not yet reached its stop coordinate
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (major_q < stop_q))
		else $error("active line past its end");

	// the final pixel closes the line
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit && st_last) |=> (!active_q && m_axis_tlast))
		else $error("line still active after its last pixel");

	// an empty result register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule
